### rtl/radix_digit_converter_unit_assert.svh
// Assertion macros for the radix digit converter checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef RADIX_DIGIT_CONVERTER_UNIT_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication
`define RDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdc assertion failed");

// next-cycle implication
`define RDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdc assertion failed");

`endif

### rtl/rdc_pkg.sv
// Shared types and constants of the radix digit converter.
// No dependencies.
package rdc_pkg;

  localparam int VALUE_W     = 31;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [RADIX_W-1:0] radix_t;

  localparam radix_t RADIX_RESET = 5'd10;
  localparam radix_t RADIX_MIN   = 5'd2;
  localparam radix_t RADIX_MAX   = 5'd16;

endpackage

### rtl/rdc_if.sv
// Valid/ready channel interfaces for the radix digit converter.
// Depends on rdc_pkg.
interface rdc_in_if import rdc_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*; ();
  logic   valid;
  logic   ready;
  digit_t digit;
  logic   last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

### rtl/rdc_front.sv
// Front end: radix register, input beat capture, value masking, radix clamp
// and reciprocal lookup. Depends on rdc_pkg and rdc_in_if.
module rdc_front import rdc_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rdc_in_if.sink                            in_chan,
  input  logic                              cfg_we,
  input  radix_t                            cfg_wdata,
  output logic                              item_valid,
  input  logic                              item_ready,
  output logic [2*VALUE_BITS+RADIX_W-1:0]   item_data
);

  localparam int QW    = VALUE_BITS;
  localparam int EXT_W = VALUE_BITS + VALUE_W;

  localparam logic [QW-1:0] RECIP_TBL [17] = '{
    QW'(0), QW'(0),
    QW'((65'd1 << QW) / 65'd2),  QW'((65'd1 << QW) / 65'd3),
    QW'((65'd1 << QW) / 65'd4),  QW'((65'd1 << QW) / 65'd5),
    QW'((65'd1 << QW) / 65'd6),  QW'((65'd1 << QW) / 65'd7),
    QW'((65'd1 << QW) / 65'd8),  QW'((65'd1 << QW) / 65'd9),
    QW'((65'd1 << QW) / 65'd10), QW'((65'd1 << QW) / 65'd11),
    QW'((65'd1 << QW) / 65'd12), QW'((65'd1 << QW) / 65'd13),
    QW'((65'd1 << QW) / 65'd14), QW'((65'd1 << QW) / 65'd15),
    QW'((65'd1 << QW) / 65'd16)
  };

  radix_t                        radix_r;
  radix_t                        radix_eff;
  logic                          item_valid_r;
  logic [2*QW+RADIX_W-1:0]       item_data_r;
  logic [EXT_W-1:0]              value_ext;
  logic [QW-1:0]                 value_masked;
  logic                          in_beat;

  assign value_ext    = {{VALUE_BITS{1'b0}}, in_chan.value};
  assign value_masked = value_ext[QW-1:0];

  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  assign in_chan.ready = !item_valid_r || item_ready;
  assign in_beat       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= RADIX_RESET;
      item_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (in_beat) begin
        item_valid_r <= 1'b1;
      end else if (item_ready) begin
        item_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      item_data_r <= {value_masked, radix_eff, RECIP_TBL[radix_eff]};
    end
  end

  assign item_valid = item_valid_r;
  assign item_data  = item_data_r;

endmodule

### rtl/rdc_queue.sv
// Short valid/ready queue between front and back end.
// Depends on rdc_pkg.
module rdc_queue import rdc_pkg::*; #(
  parameter int WIDTH = 67
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign in_ready  = cnt_r != CNT_W'(QUEUE_DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_data  = entry_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

### rtl/rdc_back.sv
// Back end: reciprocal-multiply divider, digit stack memory and pop sequencer
// with output register. Depends on rdc_pkg and rdc_out_if.
module rdc_back import rdc_pkg::*; #(
  parameter int VALUE_BITS        = 31,
  parameter int DIGIT_STACK_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [2*VALUE_BITS+RADIX_W-1:0] item_data,
  rdc_out_if.source                       out_chan
);

  localparam int QW = VALUE_BITS;
  localparam int AW = $clog2(DIGIT_STACK_DEPTH);
  localparam int PW = $clog2(DIGIT_STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  radix_t          radix_r, radix_nxt;
  logic [QW-1:0]   recip_r, recip_nxt;
  logic [2*QW-1:0] prod_r;
  logic [PW-1:0]   sp_r, sp_nxt;
  logic            out_valid_r, out_valid_nxt;
  digit_t          out_digit_r;
  logic            out_last_r;

  digit_t          stack_mem [DIGIT_STACK_DEPTH];
  digit_t          rd_data_r;

  logic [QW-1:0]   q_est;
  logic [10:0]     qr_lo;
  logic [5:0]      rem_est;
  logic [5:0]      rem_fix;
  logic            need_fix;
  digit_t          digit_val;
  logic [QW-1:0]   q_new;
  logic [PW-1:0]   sp_dec;
  logic            sp_full;
  logic            out_free;
  logic            wr_en;
  logic            rd_en;
  logic            load_out;

  assign q_est     = prod_r[2*QW-1:QW];
  assign qr_lo     = 11'(q_est[5:0]) * 11'(radix_r);
  assign rem_est   = quo_r[5:0] - qr_lo[5:0];
  assign rem_fix   = rem_est - 6'(radix_r);
  assign need_fix  = rem_est >= 6'(radix_r);
  assign digit_val = need_fix ? rem_fix[DIGIT_W-1:0] : rem_est[DIGIT_W-1:0];
  assign q_new     = need_fix ? q_est + QW'(1) : q_est;
  assign sp_dec    = sp_r - PW'(1);
  assign sp_full   = sp_r >= PW'(DIGIT_STACK_DEPTH);
  assign out_free  = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt  = state_r;
    quo_nxt    = quo_r;
    radix_nxt  = radix_r;
    recip_nxt  = recip_r;
    sp_nxt     = sp_r;
    item_ready = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          quo_nxt   = item_data[2*QW+RADIX_W-1:QW+RADIX_W];
          radix_nxt = item_data[QW+RADIX_W-1:QW];
          recip_nxt = item_data[QW-1:0];
          sp_nxt    = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_FIX;
      end
      S_FIX: begin
        if (!sp_full) begin
          wr_en  = 1'b1;
          sp_nxt = sp_r + PW'(1);
        end
        quo_nxt   = q_new;
        state_nxt = (q_new == '0) ? S_LOAD : S_MUL;
      end
      S_LOAD: begin
        rd_en     = 1'b1;
        sp_nxt    = sp_dec;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (out_free) begin
          load_out = 1'b1;
          if (sp_r != '0) begin
            rd_en  = 1'b1;
            sp_nxt = sp_dec;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    radix_r <= radix_nxt;
    recip_r <= recip_nxt;
    prod_r  <= (2*QW)'(quo_r) * (2*QW)'(recip_r);
    if (load_out) begin
      out_digit_r <= rd_data_r;
      out_last_r  <= sp_r == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[sp_r[AW-1:0]] <= digit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem[sp_dec[AW-1:0]];
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.digit      = out_digit_r;
  assign out_chan.last_digit = out_last_r;

endmodule

### rtl/radix_digit_converter_unit.sv
// Radix digit converter: converts each input value into its digits in the
// configured radix (2..16), most significant digit first, with last_digit set
// on the final digit; a zero value gives the single digit 0. The front end
// takes one beat, masks the value and clamps the radix (0 and 1 act as 2,
// 17..31 act as 16), then hands the item through a two-entry queue to the
// back end, which handles one item at a time. For each digit of an item the
// shared divider does one reciprocal multiply, then one correction step; the
// digits are then popped from the digit stack memory, after a hand-off of item
// pickup and the first stack read, and every stall of the result channel holds
// the pop phase. The front end keeps taking beats while the back end works,
// until the queue fills. The digit stack needs no clearing pass after reset.
module radix_digit_converter_unit import rdc_pkg::*; #(
  parameter int DIGIT_STACK_DEPTH = 32,
  parameter int VALUE_BITS        = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  rdc_in_if.sink     in_chan,
  rdc_out_if.source  out_chan,
  input  logic       cfg_we,
  input  radix_t     cfg_wdata
);

  localparam int ITEM_W = 2 * VALUE_BITS + RADIX_W;

  logic              f_valid;
  logic              f_ready;
  logic [ITEM_W-1:0] f_data;
  logic              b_valid;
  logic              b_ready;
  logic [ITEM_W-1:0] b_data;

  rdc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item_data  (f_data)
  );

  rdc_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  rdc_back #(
    .VALUE_BITS        (VALUE_BITS),
    .DIGIT_STACK_DEPTH (DIGIT_STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item_data  (b_data),
    .out_chan   (out_chan)
  );

endmodule

### rtl/rdc_checker.sv
// Port-level checker for the radix digit converter and its bind.
// Depends on rdc_pkg and radix_digit_converter_unit_assert.svh.
`include "radix_digit_converter_unit_assert.svh"

module rdc_checker import rdc_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   cfg_we,
  input radix_t cfg_wdata,
  input logic   out_valid,
  input logic   out_ready,
  input digit_t out_digit,
  input logic   out_last
);

  radix_t radix_r;
  radix_t radix_eff;
  radix_t out_digit_ext;
  logic   first_r;

  assign out_digit_ext = {1'b0, out_digit};

  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      first_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        first_r <= out_last;
      end
    end
  end

  `RDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_digit) && $stable(out_last))
  `RDC_ASSERT_NOW(a_digit_range, out_valid, out_digit_ext < radix_eff)
  `RDC_ASSERT_NOW(a_lead_nonzero, out_valid && first_r && !out_last, out_digit != '0)

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_digit (out_chan.digit),
  .out_last  (out_chan.last_digit)
);

### bench/radix_digit_converter_unit_tb.sv
// Self-checking bench for radix_digit_converter_unit: random and directed values over
// several radix settings, digits predicted by repeated division and checked per beat.
// Depends on rdc_pkg, rdc_in_if/rdc_out_if and the unit itself.
module radix_digit_converter_unit_tb;
  import rdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 120;

  typedef struct {
    digit_t digit;
    logic   last_digit;
  } digit_beat_t;

  function automatic int unsigned effective_base(radix_t r);
    if (r < RADIX_MIN) return 32'(RADIX_MIN);
    if (r > RADIX_MAX) return 32'(RADIX_MAX);
    return 32'(r);
  endfunction

  class digit_scoreboard;
    digit_beat_t pending_digits[$];
    radix_t      radix_reg;
    int          mismatches;

    function new();
      radix_reg  = RADIX_RESET;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function void note_value(value_t v);
      int unsigned base;
      int unsigned quotient;
      digit_t      stack[$];
      digit_beat_t beat;
      base     = effective_base(radix_reg);
      quotient = 32'(v);
      do begin
        stack.push_back(digit_t'(quotient % base));
        quotient = quotient / base;
      end while (quotient != 0);
      for (int i = stack.size() - 1; i >= 0; i--) begin
        beat.digit      = stack[i];
        beat.last_digit = (i == 0);
        pending_digits.push_back(beat);
      end
    endfunction

    task check_digit(digit_t digit, logic last_digit);
      digit_beat_t want;
      if (pending_digits.size() == 0) begin
        report($sformatf("digit %0d last %0b with nothing pending", digit, last_digit));
      end else begin
        want = pending_digits.pop_front();
        if (digit !== want.digit)
          report($sformatf("digit %0d, expected %0d", digit, want.digit));
        if (last_digit !== want.last_digit)
          report($sformatf("last_digit %0b, expected %0b", last_digit, want.last_digit));
      end
    endtask
  endclass

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  radix_t cfg_wdata;
  int     in_idle_pct;
  int     out_stall_pct;
  int     quiet_cycles = 0;

  digit_scoreboard sb = new();

  rdc_in_if  in_chan ();
  rdc_out_if out_chan ();

  radix_digit_converter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_value(in_chan.value);
      if (out_chan.valid && out_chan.ready)
        sb.check_digit(out_chan.digit, out_chan.last_digit);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
          $display("** radix_digit_converter_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task send_value(value_t v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.value <= v;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task drain_digits();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_digits.size() != 0) @(posedge clk);
  endtask

  task write_radix(radix_t r);
    drain_digits();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.radix_reg  = r;
  endtask

  function automatic value_t pick_value(radix_t r);
    int unsigned base;
    int unsigned power;
    base = effective_base(r);
    case ($urandom_range(9))
      0: return '0;
      1, 2: return value_t'($urandom_range(1000));
      3: begin
        power = 1;
        repeat ($urandom_range(1, 30))
          if (power <= 32'h7FFF_FFFF / base) power = power * base;
        return value_t'(power - $urandom_range(1));
      end
      4: return '1;
      default: return value_t'($urandom);
    endcase
  endfunction

  initial begin
    radix_t next_radix;
    in_chan.valid = 1'b0;
    in_chan.value = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = RADIX_RESET;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset radix, then each clamp region and both ends of the range
    send_value('0);
    send_value(31'd1);
    send_value(31'd9);
    send_value(31'd10);
    send_value('1);
    send_value(31'd999_999_999);
    write_radix(RADIX_MIN);
    send_value('0);
    send_value(31'd1);
    send_value('1);
    send_value(31'h1555_5555);
    send_value(31'h2AAA_AAAA);
    write_radix(RADIX_MAX);
    send_value('0);
    send_value(31'd15);
    send_value(31'd16);
    send_value('1);
    send_value(31'h0FED_CBA9);
    write_radix(5'd0);
    send_value(31'd6);
    write_radix(5'd1);
    send_value('1);
    write_radix(5'd17);
    send_value(31'd255);
    write_radix(5'd31);
    send_value(31'h1234_5678);
    write_radix(5'd3);
    send_value('1);
    write_radix(5'd15);
    send_value(31'd224);

    for (int round = 0; round < 8; round++) begin
      next_radix = (round % 3 == 0) ? radix_t'($urandom_range(31))
                                    : radix_t'($urandom_range(RADIX_MIN, RADIX_MAX));
      write_radix(next_radix);
      case (round % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 51; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 51; end
        default: begin in_idle_pct = 17; out_stall_pct = 17; end
      endcase
      repeat (42) send_value(pick_value(next_radix));
    end

    drain_digits();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_digits.size() == 0) begin
      $display("** radix_digit_converter_unit: PASSED **");
    end else begin
      $display("** radix_digit_converter_unit: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rdc_pkg.sv
rtl/rdc_if.sv
rtl/rdc_front.sv
rtl/rdc_queue.sv
rtl/rdc_back.sv
rtl/radix_digit_converter_unit.sv
rtl/rdc_checker.sv
bench/radix_digit_converter_unit_tb.sv
